// File: src/sebp_pkg.sv
package sebp_pkg;

    localparam int COUNT_W   = 16;
    localparam int WORD_W    = 64;
    localparam int BIT_CNT_W = 7;

    // Transfer counts that select the long (14-bit) address form.
    localparam logic [COUNT_W-1:0] LONG_COUNT_A = 16'h0011;
    localparam logic [COUNT_W-1:0] LONG_COUNT_B = 16'h0051;

    // Bit counter marks within one command.
    localparam logic [BIT_CNT_W-1:0] ADDR_FIRST_BIT = 7'd3;
    localparam logic [BIT_CNT_W-1:0] SHORT_ADDR_END = 7'd9;
    localparam logic [BIT_CNT_W-1:0] LONG_ADDR_END  = 7'h11;
    localparam logic [BIT_CNT_W-1:0] DUMMY_READS    = 7'd4;
    localparam logic [BIT_CNT_W-1:0] WORD_END       = 7'h40;
    localparam logic [BIT_CNT_W-1:0] STOP_END       = 7'h41;

    typedef struct packed {
        logic               action;
        logic               write_bit;
        logic [COUNT_W-1:0] dma_count;
    } t_item;

    typedef struct packed {
        logic read_bit;
        logic committed;
        logic large_size;
        logic in_use;
    } t_result;

endpackage

// File: src/sebp_ram.sv
module sebp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/sebp_core.sv
module sebp_core #(
    parameter int STORE_WORDS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  sebp_pkg::t_item                     i_item,
    input  logic [sebp_pkg::WORD_W-1:0]         i_rd_data,
    output sebp_pkg::t_result                   o_result,
    output logic [$clog2(STORE_WORDS)-1:0]      o_rd_addr,
    output logic                                o_wr_en,
    output logic [$clog2(STORE_WORDS)-1:0]      o_wr_addr,
    output logic [sebp_pkg::WORD_W-1:0]         o_wr_data
);
    import sebp_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [AW:0] MODULUS = (AW + 1)'(STORE_WORDS);

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_ADDR   = 5'b00010,
        MODE_RDWAIT = 5'b00100,
        MODE_RDDATA = 5'b01000,
        MODE_WRDATA = 5'b10000
    } t_mode;

    t_mode                r_mode,     n_mode;
    logic [BIT_CNT_W-1:0] r_bit_cnt,  n_bit_cnt;
    logic [AW-1:0]        r_word_addr, n_word_addr;
    logic [WORD_W-1:0]    r_shift,    n_shift;
    logic [AW-1:0]        r_residue,  n_residue;
    logic                 r_used,     n_used;
    logic                 r_long,     n_long;

    logic [BIT_CNT_W-1:0] w_cnt_inc;
    logic [WORD_W-1:0]    w_shift_in;
    logic [AW:0]          w_res_dbl;
    logic [AW-1:0]        w_res_step;
    logic                 w_long_cnt;
    logic                 w_cmd_read;
    logic                 w_read_bit;
    logic                 w_commit;

    assign w_cnt_inc  = r_bit_cnt + 1'b1;
    assign w_shift_in = {r_shift[WORD_W-2:0], i_item.write_bit};
    assign w_long_cnt = (i_item.dma_count == LONG_COUNT_A) ||
                        (i_item.dma_count == LONG_COUNT_B);

    // Running remainder of the long address: one doubling and one
    // conditional subtract per address bit keeps it below the store depth.
    assign w_res_dbl  = {r_residue, i_item.write_bit};
    assign w_res_step = (w_res_dbl >= MODULUS) ? AW'(w_res_dbl - MODULUS) : w_res_dbl[AW-1:0];

    always_comb begin
        n_mode      = r_mode;
        n_bit_cnt   = r_bit_cnt;
        n_word_addr = r_word_addr;
        n_shift     = r_shift;
        n_residue   = r_residue;
        n_used      = r_used;
        n_long      = r_long;
        w_read_bit  = 1'b0;
        w_commit    = 1'b0;
        w_cmd_read  = 1'b0;

        if (!i_item.action) begin
            unique case (r_mode)
                MODE_RDWAIT: begin
                    n_bit_cnt = w_cnt_inc;
                    if (w_cnt_inc == DUMMY_READS) begin
                        n_mode    = MODE_RDDATA;
                        n_bit_cnt = '0;
                    end
                end
                MODE_RDDATA: begin
                    w_read_bit = i_rd_data[~r_bit_cnt[5:0]];
                    n_bit_cnt  = w_cnt_inc;
                    if (w_cnt_inc == WORD_END) begin
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    w_read_bit = 1'b1;
                end
            endcase
        end else if (i_item.dma_count != '0) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    n_shift   = w_shift_in;
                    n_bit_cnt = BIT_CNT_W'(1);
                    n_mode    = MODE_ADDR;
                end
                MODE_ADDR: begin
                    n_shift   = w_shift_in;
                    n_bit_cnt = w_cnt_inc;
                    n_residue = (w_cnt_inc == ADDR_FIRST_BIT) ?
                                AW'(i_item.write_bit) : w_res_step;
                    if (w_long_cnt && w_cnt_inc == LONG_ADDR_END) begin
                        n_long      = 1'b1;
                        n_used      = 1'b1;
                        n_word_addr = r_residue;
                        w_cmd_read  = r_shift[14];
                    end else if (!w_long_cnt && w_cnt_inc == SHORT_ADDR_END) begin
                        n_long      = 1'b0;
                        n_used      = 1'b1;
                        n_word_addr = AW'(r_shift[5:0]);
                        w_cmd_read  = r_shift[6];
                    end
                    if ((w_long_cnt && w_cnt_inc == LONG_ADDR_END) ||
                        (!w_long_cnt && w_cnt_inc == SHORT_ADDR_END)) begin
                        if (w_cmd_read) begin
                            n_mode    = MODE_RDWAIT;
                            n_bit_cnt = '0;
                        end else begin
                            // The bit that closes the address is the first data bit.
                            n_mode    = MODE_WRDATA;
                            n_bit_cnt = BIT_CNT_W'(1);
                        end
                    end
                end
                MODE_RDWAIT, MODE_RDDATA: begin
                    n_mode = MODE_IDLE;
                end
                MODE_WRDATA: begin
                    n_shift   = w_shift_in;
                    n_bit_cnt = w_cnt_inc;
                    if (w_cnt_inc == WORD_END) begin
                        n_used   = 1'b1;
                        w_commit = 1'b1;
                    end else if (w_cnt_inc == STOP_END) begin
                        n_mode    = MODE_IDLE;
                        n_bit_cnt = '0;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_bit_cnt   <= '0;
            r_word_addr <= '0;
            r_used      <= 1'b0;
            r_long      <= 1'b0;
        end else if (i_advance) begin
            r_mode      <= n_mode;
            r_bit_cnt   <= n_bit_cnt;
            r_word_addr <= n_word_addr;
            r_used      <= n_used;
            r_long      <= n_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_shift   <= n_shift;
            r_residue <= n_residue;
        end
    end

    assign o_result.read_bit   = w_read_bit;
    assign o_result.committed  = w_commit;
    assign o_result.large_size = n_long;
    assign o_result.in_use     = n_used;

    assign o_rd_addr = r_word_addr;
    assign o_wr_en   = i_advance && w_commit;
    assign o_wr_addr = r_word_addr;
    assign o_wr_data = w_shift_in;

endmodule

// File: src/serial_eeprom_bit_protocol_unit.sv
// Bit-serial EEPROM device model for a one-bit bus port. Each request is one
// bus access: a write access shifts one bit into the command engine, a read
// access returns one bit, and every request yields exactly one result. A
// command is a start bit, a command bit (1 = read, 0 = write) and a 6-bit
// address, or a 14-bit one when the transfer count is 0x11 or 0x51; the
// address is reduced modulo STORE_WORDS. A read command is followed by four
// dummy zeros and then the 64 bits of the word, most significant bit first.
// A write command is followed by 64 data bits, committed on the 64th, and a
// stop bit. Write accesses with a zero transfer count change nothing.
// Rate: one request per clock sustained while results are drained and no
// clearing pass runs. A request is captured in the input register, moves
// through the engine into the result register once that register is empty
// or being drained, and is presented on the outputs from there. The word
// store is a single-port-write, registered-read RAM; after reset a
// clearing pass fills it with all ones, during which no request is accepted.
module serial_eeprom_bit_protocol_unit #(
    parameter int STORE_WORDS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_action,
    input  logic                         i_write_bit,
    input  logic [sebp_pkg::COUNT_W-1:0] i_dma_count,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_read_bit,
    output logic                         o_committed,
    output logic                         o_large_size,
    output logic                         o_in_use
);
    import sebp_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);

    // Input register stage.
    logic    r_in_valid;
    t_item   r_item;
    // Result register stage.
    logic    r_out_valid;
    t_result r_result;
    // Clearing pass sequencer.
    logic    r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic          w_accept;
    logic          w_advance;
    t_result       w_result;
    logic [AW-1:0] w_rd_addr;
    logic          w_core_wr_en;
    logic [AW-1:0] w_core_wr_addr;
    logic [WORD_W-1:0] w_core_wr_data;
    logic [WORD_W-1:0] w_rd_data;
    logic          w_ram_wr_en;
    logic [AW-1:0] w_ram_wr_addr;
    logic [WORD_W-1:0] w_ram_wr_data;

    // A request moves from the input register into the engine whenever the
    // result register is empty or being drained, so a waiting result does not
    // stop a request from being captured while the input register is empty.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_in_valid || w_advance);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action    <= i_action;
            r_item.write_bit <= i_write_bit;
            r_item.dma_count <= i_dma_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    // The store resets to all ones; the clearing pass writes one word per
    // cycle, starting at address zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(STORE_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    sebp_core #(
        .STORE_WORDS(STORE_WORDS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_item),
        .i_rd_data (w_rd_data),
        .o_result  (w_result),
        .o_rd_addr (w_rd_addr),
        .o_wr_en   (w_core_wr_en),
        .o_wr_addr (w_core_wr_addr),
        .o_wr_data (w_core_wr_data)
    );

    // No request is accepted while clearing, so the engine never writes then.
    assign w_ram_wr_en   = r_clearing || w_core_wr_en;
    assign w_ram_wr_addr = r_clearing ? r_clr_addr : w_core_wr_addr;
    assign w_ram_wr_data = r_clearing ? '1 : w_core_wr_data;

    sebp_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STORE_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_out_valid  = r_out_valid;
    assign o_read_bit   = r_result.read_bit;
    assign o_committed  = r_result.committed;
    assign o_large_size = r_result.large_size;
    assign o_in_use     = r_result.in_use;

endmodule

// File: src/sebp_checker.sv
module sebp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_read_bit,
    input logic o_committed,
    input logic o_large_size,
    input logic o_in_use
);

    logic r_seen_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_in_use <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_in_use) begin
            r_seen_in_use <= 1'b1;
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
        $stable(o_read_bit) && $stable(o_committed) &&
        $stable(o_large_size) && $stable(o_in_use))
        else $error("result changed while stalled");

    // A commit comes from a write access, which returns zero.
    a_commit_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_committed |-> !o_read_bit)
        else $error("commit reported with a read bit of one");

    // Address width is only known once an address phase has finished.
    a_large_needs_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_large_size |-> o_in_use)
        else $error("long address reported before any address phase");

    a_commit_needs_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_committed |-> o_in_use)
        else $error("commit reported while not in use");

    // The in-use flag never drops once it has been delivered.
    a_in_use_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_in_use |-> o_in_use)
        else $error("in-use flag cleared");

endmodule

bind serial_eeprom_bit_protocol_unit sebp_checker u_sebp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_bit   (o_read_bit),
    .o_committed  (o_committed),
    .o_large_size (o_large_size),
    .o_in_use     (o_in_use)
);

// File: tb/tb_serial_eeprom_bit_protocol_unit.sv
`timescale 1ns / 1ps

module tb_serial_eeprom_bit_protocol_unit;
    import sebp_pkg::*;

    localparam int STORE_WORDS     = 1024;
    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_REQUESTS = 950;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int READ_LENGTH     = 68;
    localparam int POOL_DEPTH      = 16;
    localparam int REPORT_LIMIT    = 10;

    // Phases of the command engine, tracked by the mirror below.
    typedef enum logic [2:0] {
        M_IDLE,
        M_ADDR,
        M_RDWAIT,
        M_RDDATA,
        M_WRDATA
    } t_engine_mode;

    // The mirror keeps its own copy of the engine state and the word array. Each
    // accepted request advances that copy and queues the one result it causes;
    // each result that leaves the block is compared with the oldest queued one.
    class t_eeprom_mirror;
        t_engine_mode mode;
        bit [6:0]     bit_cnt;
        bit [3:0]     byte_idx;
        bit [9:0]     word_addr;
        bit [7:0]     shift_reg [9];
        bit [63:0]    words [STORE_WORDS];
        bit           used;
        bit           long_addr;
        t_result      awaited_results [$];
        int           failures;
        int           results_seen;

        function new();
            mode      = M_IDLE;
            bit_cnt   = '0;
            byte_idx  = '0;
            word_addr = '0;
            used      = 1'b0;
            long_addr = 1'b0;
            failures  = 0;
            results_seen = 0;
            foreach (shift_reg[i]) shift_reg[i] = '0;
            foreach (words[i]) words[i] = '1;
        endfunction

        // Shifts one bit into the byte that the byte index points at. Once the
        // index has run past the last byte, the bit is lost but still counted.
        function void shift_bit(bit b);
            if (byte_idx < 9) shift_reg[byte_idx] = {shift_reg[byte_idx][6:0], b};
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt[2:0] == 3'd0) byte_idx = byte_idx + 1'b1;
        endfunction

        // The address phase is over. The command bit sits at bit 6 of the first
        // byte: zero starts a write, whose first data bit is the one that ended
        // the address, and one starts a read with its dummy bits.
        function void end_address(bit [13:0] addr, bit is_long, bit b);
            long_addr = is_long;
            used      = 1'b1;
            word_addr = 10'(addr % STORE_WORDS);
            if (!shift_reg[0][6]) begin
                shift_reg[0] = {7'd0, b};
                bit_cnt  = 7'd1;
                byte_idx = '0;
                mode     = M_WRDATA;
            end else begin
                mode     = M_RDWAIT;
                bit_cnt  = '0;
                byte_idx = '0;
            end
        endfunction

        function void note_request(t_item req);
            t_result   res;
            bit        rbit;
            bit        commit;
            bit [5:0]  pos;
            bit        is_long;
            rbit    = 1'b0;
            commit  = 1'b0;
            is_long = (req.dma_count == LONG_COUNT_A) || (req.dma_count == LONG_COUNT_B);
            if (!req.action) begin
                case (mode)
                    M_RDWAIT: begin
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt == DUMMY_READS) begin
                            mode     = M_RDDATA;
                            bit_cnt  = '0;
                            byte_idx = '0;
                        end
                    end
                    M_RDDATA: begin
                        pos     = bit_cnt[5:0];
                        rbit    = words[word_addr][63 - pos];
                        bit_cnt = bit_cnt + 1'b1;
                        if (bit_cnt[2:0] == 3'd0) byte_idx = byte_idx + 1'b1;
                        if (bit_cnt == WORD_END) mode = M_IDLE;
                    end
                    default: rbit = 1'b1;
                endcase
            end else if (req.dma_count != '0) begin
                case (mode)
                    M_IDLE: begin
                        byte_idx     = '0;
                        bit_cnt      = 7'd1;
                        shift_reg[0] = {7'd0, req.write_bit};
                        mode         = M_ADDR;
                    end
                    M_ADDR: begin
                        shift_bit(req.write_bit);
                        if (is_long) begin
                            if (bit_cnt == LONG_ADDR_END)
                                end_address({shift_reg[0][5:0], shift_reg[1]}, 1'b1,
                                            req.write_bit);
                        end else if (bit_cnt == SHORT_ADDR_END) begin
                            end_address({8'd0, shift_reg[0][5:0]}, 1'b0, req.write_bit);
                        end
                    end
                    M_RDWAIT, M_RDDATA: mode = M_IDLE;
                    M_WRDATA: begin
                        shift_bit(req.write_bit);
                        if (bit_cnt == WORD_END) begin
                            words[word_addr] = {shift_reg[0], shift_reg[1], shift_reg[2],
                                                shift_reg[3], shift_reg[4], shift_reg[5],
                                                shift_reg[6], shift_reg[7]};
                            used   = 1'b1;
                            commit = 1'b1;
                        end else if (bit_cnt == STOP_END) begin
                            mode     = M_IDLE;
                            byte_idx = '0;
                            bit_cnt  = '0;
                        end
                    end
                    default: mode = M_IDLE;
                endcase
            end
            res.read_bit   = rbit;
            res.committed  = commit;
            res.large_size = long_addr;
            res.in_use     = used;
            awaited_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            bit      bad;
            results_seen++;
            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("result %0d arrived with no request outstanding: %b",
                             results_seen, got);
                return;
            end
            exp = awaited_results.pop_front();
            bad = (got.read_bit !== exp.read_bit) || (got.committed !== exp.committed) ||
                  (got.large_size !== exp.large_size) || (got.in_use !== exp.in_use);
            if (bad) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("result %0d mismatch:", results_seen);
                    $display("  expected read_bit=%b committed=%b large_size=%b in_use=%b",
                             exp.read_bit, exp.committed, exp.large_size, exp.in_use);
                    $display("  got      read_bit=%b committed=%b large_size=%b in_use=%b",
                             got.read_bit, got.committed, got.large_size, got.in_use);
                end
            end
        endfunction
    endclass

    // Every input of the block starts at a known value; reset is held low
    // from time zero.
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_action  = 1'b0;
    logic                in_write_bit = 1'b0;
    logic [COUNT_W-1:0]  in_dma_count = '0;
    logic                out_ready  = 1'b0;
    logic                hold_off   = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic                read_bit;
    logic                committed;
    logic                large_size;
    logic                in_use;

    t_eeprom_mirror      mirror;
    int                  accepted_requests = 0;
    int                  useful_requests   = 0;
    int                  burst_left        = 0;
    int                  cycle_count       = 0;
    logic [9:0]          written_words [$];

    serial_eeprom_bit_protocol_unit #(
        .STORE_WORDS(STORE_WORDS)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_action     (in_action),
        .i_write_bit  (in_write_bit),
        .i_dma_count  (in_dma_count),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_read_bit   (read_bit),
        .o_committed  (committed),
        .o_large_size (large_size),
        .o_in_use     (in_use)
    );

    always #5 clk = ~clk;

    // The watchdog covers the clearing pass, the long hold-off and the
    // slowest mix of sender gaps and receiver stalls several times over.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // A transfer count for one bus access. Long counts select the 14-bit
    // address form; short counts are any other nonzero value.
    function automatic logic [COUNT_W-1:0] pick_count(input bit is_long);
        logic [COUNT_W-1:0] c;
        if (is_long) return $urandom_range(0, 1) ? LONG_COUNT_A : LONG_COUNT_B;
        c = COUNT_W'($urandom_range(1, 65535));
        while (c == LONG_COUNT_A || c == LONG_COUNT_B) c = COUNT_W'($urandom_range(1, 65535));
        return c;
    endfunction

    // Reads mostly target words that were written recently so that stored
    // data comes back out; the rest go anywhere the address form can reach.
    function automatic logic [13:0] read_address(input bit is_long);
        logic [9:0] idx;
        logic [3:0] hi;
        hi = 4'($urandom_range(0, 15));
        if (written_words.size() > 0 && $urandom_range(0, 9) < 7)
            idx = written_words[$urandom_range(0, written_words.size() - 1)];
        else
            idx = 10'($urandom_range(0, STORE_WORDS - 1));
        if (is_long) return {hi, idx};
        return {8'd0, idx[5:0]};
    endfunction

    // Offers one request and waits for it to be taken. The sender works in
    // bursts; between bursts it usually drops valid for a random gap. Every few bursts
    // are long ones, so there are stretches with no idling at all.
    task automatic offer(input logic act, input logic b, input logic [COUNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid     <= 1'b1;
        in_action    <= act;
        in_write_bit <= b;
        in_dma_count <= cnt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        mirror.note_request({act, b, cnt});
        accepted_requests++;
        if (!(act && cnt == '0)) useful_requests++;
    endtask

    // Now and then a stray request lands inside a command: a write with a zero
    // count, which the block ignores, or, where the engine is not streaming
    // read data, a read that just returns one.
    task automatic maybe_interject(input bit reads_ok);
        if ($urandom_range(0, 24) == 0) begin
            if (reads_ok && $urandom_range(0, 1))
                offer(1'b0, 1'($urandom_range(0, 1)), COUNT_W'($urandom_range(0, 65535)));
            else
                offer(1'b1, 1'($urandom_range(0, 1)), '0);
        end
    endtask

    task automatic send_bit(input logic b, input logic [COUNT_W-1:0] cnt);
        maybe_interject(1'b1);
        offer(1'b1, b, cnt);
    endtask

    // Start bit, command bit zero, address, 64 data bits with the most
    // significant first, then the stop bit.
    task automatic write_command(input bit is_long, input logic [13:0] addr,
                                 input logic [63:0] data);
        int width;
        width = is_long ? 14 : 6;
        send_bit(1'b1, pick_count(is_long));
        send_bit(1'b0, pick_count(is_long));
        for (int i = width - 1; i >= 0; i--) send_bit(addr[i], pick_count(is_long));
        for (int i = 63; i >= 0; i--) send_bit(data[i], pick_count(is_long));
        send_bit(1'($urandom_range(0, 1)), pick_count(1'b0));
        written_words.push_back(addr[9:0]);
        if (written_words.size() > POOL_DEPTH) void'(written_words.pop_front());
    endtask

    // Start bit, command bit one, address and one trailing bit, then the read
    // requests. A short read is cut off by a write, which aborts it.
    task automatic read_command(input bit is_long, input logic [13:0] addr,
                                input int reads);
        int width;
        width = is_long ? 14 : 6;
        send_bit(1'b1, pick_count(is_long));
        send_bit(1'b1, pick_count(is_long));
        for (int i = width - 1; i >= 0; i--) send_bit(addr[i], pick_count(is_long));
        send_bit(1'($urandom_range(0, 1)), pick_count(is_long));
        for (int n = 0; n < reads; n++) begin
            maybe_interject(1'b0);
            offer(1'b0, 1'($urandom_range(0, 1)), COUNT_W'($urandom_range(0, 65535)));
        end
        if (reads < READ_LENGTH)
            offer(1'b1, 1'($urandom_range(0, 1)), pick_count(1'($urandom_range(0, 1))));
    endtask

    // Brings the engine back to idle after noise: short-count writes end any
    // address phase, run out a write and abort a read.
    task automatic resync();
        while (mirror.mode != M_IDLE)
            offer(1'b1, 1'($urandom_range(0, 1)), pick_count(1'b0));
    endtask

    // Receiver: it takes results and checks them, and changes its stall style
    // every so often between always ready, half the time, and rarely ready.
    initial begin
        int      style_left;
        int      style;
        logic    rdy;
        t_result got;
        style_left = 0;
        style      = 0;
        forever begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready) begin
                got = {read_bit, committed, large_size, in_use};
                mirror.check_result(got);
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 2);
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (style)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
            out_ready <= hold_off ? 1'b0 : rdy;
        end
    end

    // Once traffic is flowing, the receiver holds off for a long stretch while
    // the sender keeps offering requests, so the block fills and stalls.
    initial begin
        while (accepted_requests < HOLD_OFF_AFTER) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        int          random_start;
        int          pick;
        bit          is_long;
        int          reads;
        logic [13:0] addr;
        logic [63:0] data;
        mirror = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Reads while idle return one and a zero-count write is
        // ignored. Then a short read of the top 6-bit address, with a read in
        // the middle of the address phase, its four dummy zeros and a few data
        // bits of a word that was never written, a zero-count write that must
        // not disturb the read, and a write that aborts it.
        offer(1'b0, 1'b0, 16'h0000);
        offer(1'b1, 1'b1, 16'h0000);
        offer(1'b0, 1'b1, 16'hFFFF);
        offer(1'b1, 1'b1, 16'hFFFF);
        offer(1'b1, 1'b1, 16'h0001);
        offer(1'b0, 1'b0, 16'h0001);
        repeat (6) offer(1'b1, 1'b1, 16'hFFFF);
        offer(1'b1, 1'b0, 16'h0001);
        repeat (7) offer(1'b0, 1'b1, 16'h5555);
        offer(1'b1, 1'b0, 16'h0000);
        offer(1'b1, 1'b1, 16'hAAAA);
        offer(1'b0, 1'b0, 16'h0000);

        // Random part: mostly complete commands with random content, some
        // noise, and now and then an address phase whose count switches from
        // long to short, so the bit counter wraps and shifts past the last
        // byte are dropped.
        random_start = useful_requests;
        while (useful_requests - random_start < RANDOM_REQUESTS) begin
            pick    = $urandom_range(0, 99);
            is_long = 1'($urandom_range(0, 1));
            if (pick < 30) begin
                addr = 14'($urandom_range(0, 16383));
                if (!is_long) addr[13:6] = '0;
                else if ($urandom_range(0, 1)) addr[9:6] = '0;
                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = '1;
                    default: data = {$urandom, $urandom};
                endcase
                write_command(is_long, addr, data);
            end else if (pick < 65) begin
                reads = ($urandom_range(0, 4) == 0) ? $urandom_range(0, READ_LENGTH - 1)
                                                    : READ_LENGTH;
                read_command(is_long, read_address(is_long), reads);
            end else if (pick < 96) begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0:       offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       '0);
                        1:       offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       pick_count(1'b1));
                        default: offer(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       COUNT_W'($urandom_range(0, 65535)));
                    endcase
                end
                resync();
            end else begin
                offer(1'b1, 1'b1, pick_count(1'b1));
                repeat (9) offer(1'b1, 1'($urandom_range(0, 1)), pick_count(1'b1));
                resync();
            end
        end

        in_valid <= 1'b0;
        while (mirror.awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.failures == 0 && mirror.awaited_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
